// ----- src/cascaded_sensor_filter_macros.svh -----
// ----------------------------------------------------------------------------
// cascaded_sensor_filter_macros.svh
// Assertion macros shared by the cascaded sensor filter.
// ----------------------------------------------------------------------------
`ifndef CASCADED_SENSOR_FILTER_MACROS_SVH
`define CASCADED_SENSOR_FILTER_MACROS_SVH

// same-cycle implication, disabled in reset
`define CSF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("csf assertion failed");

// next-cycle implication, disabled in reset
`define CSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("csf assertion failed");

`endif

// ----- src/csf_pkg.sv -----
// ----------------------------------------------------------------------------
// csf_pkg
// Types, constants and helpers of the cascaded sensor filter.
// ----------------------------------------------------------------------------
`default_nettype none

package csf_pkg;

    localparam int DATA_W   = 32;
    localparam int WEIGHT_W = 17;
    localparam int EXT_W    = 38;
    localparam int PROD_W   = EXT_W + WEIGHT_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

    localparam logic signed [EXT_W-1:0] DATA_MAX_EXT = 38'sh00_7FFF_FFFF;
    localparam logic signed [EXT_W-1:0] DATA_MIN_EXT = -38'sh00_8000_0000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHAIN_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LPF_WEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CF_WEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KF_Q       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KF_R       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_DT    = 3'd5;

    // chain modes
    localparam logic [2:0] MODE_KF      = 3'd0;
    localparam logic [2:0] MODE_CF      = 3'd1;
    localparam logic [2:0] MODE_LP      = 3'd2;
    localparam logic [2:0] MODE_LP_KF   = 3'd3;
    localparam logic [2:0] MODE_CF_KF   = 3'd4;
    localparam logic [2:0] MODE_ALL     = 3'd5;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LP_SET, ST_LP_MUL, ST_LP_UPD,
        ST_CF_GSET, ST_CF_GMUL, ST_CF_GUPD, ST_CF_ASET, ST_CF_AMUL, ST_CF_UPD,
        ST_KF_P, ST_KF_DEN, ST_KF_DINIT, ST_KF_DIV, ST_KF_GAIN,
        ST_KF_XSET, ST_KF_XMUL, ST_KF_XUPD, ST_KF_PSET, ST_KF_PMUL, ST_KF_PUPD,
        ST_ZERO, ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_MUL,
        OP_LP_SET, OP_LP_UPD,
        OP_CF_GSET, OP_CF_GUPD, OP_CF_ASET, OP_CF_UPD,
        OP_KF_P, OP_KF_DEN, OP_KF_DINIT, OP_KF_DIV, OP_KF_GAIN,
        OP_KF_XSET, OP_KF_XUPD, OP_KF_PSET, OP_KF_PUPD,
        OP_ZERO, OP_EMIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic sel_cur;   // gyro input of the complementary stage is the low-pass output
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } status_t;

    // a weight above one acts as one
    function automatic logic [WEIGHT_W-1:0] wclamp(input logic [WEIGHT_W-1:0] w);
        return (w > WEIGHT_ONE) ? WEIGHT_ONE : w;
    endfunction

    // clip to the data range; bit DATA_W flags a clip
    function automatic logic [DATA_W:0] clip(input logic signed [EXT_W-1:0] v);
        logic [DATA_W:0] r;
        if (v > DATA_MAX_EXT) begin
            r = {1'b1, DATA_MAX_EXT[DATA_W-1:0]};
        end else if (v < DATA_MIN_EXT) begin
            r = {1'b1, DATA_MIN_EXT[DATA_W-1:0]};
        end else begin
            r = {1'b0, v[DATA_W-1:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/csf_ctrl.sv -----
// ----------------------------------------------------------------------------
// csf_ctrl
// Sequencer of the filter chain: steps the datapath through the stages.
// ----------------------------------------------------------------------------
`default_nettype none

module csf_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [2:0]       chain_mode,
    input  wire csf_pkg::status_t status,
    output csf_pkg::cmd_t         cmd
);
    import csf_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (chain_mode)
                        MODE_KF:                       state_next = ST_KF_P;
                        MODE_CF, MODE_CF_KF:           state_next = ST_CF_GSET;
                        MODE_LP, MODE_LP_KF, MODE_ALL: state_next = ST_LP_SET;
                        default:                       state_next = ST_ZERO;
                    endcase
                end
            end
            ST_LP_SET:  state_next = ST_LP_MUL;
            ST_LP_MUL:  state_next = ST_LP_UPD;
            ST_LP_UPD: begin
                if (chain_mode == MODE_LP) begin
                    state_next = ST_DONE;
                end else if (chain_mode == MODE_LP_KF) begin
                    state_next = ST_KF_P;
                end else begin
                    state_next = ST_CF_GSET;
                end
            end
            ST_CF_GSET: state_next = ST_CF_GMUL;
            ST_CF_GMUL: state_next = ST_CF_GUPD;
            ST_CF_GUPD: state_next = ST_CF_ASET;
            ST_CF_ASET: state_next = ST_CF_AMUL;
            ST_CF_AMUL: state_next = ST_CF_UPD;
            ST_CF_UPD: begin
                state_next = (chain_mode == MODE_CF) ? ST_DONE : ST_KF_P;
            end
            ST_KF_P:     state_next = ST_KF_DEN;
            ST_KF_DEN:   state_next = ST_KF_DINIT;
            ST_KF_DINIT: state_next = ST_KF_DIV;
            ST_KF_DIV: begin
                if (status.div_last) begin
                    state_next = ST_KF_GAIN;
                end
            end
            ST_KF_GAIN: state_next = ST_KF_XSET;
            ST_KF_XSET: state_next = ST_KF_XMUL;
            ST_KF_XMUL: state_next = ST_KF_XUPD;
            ST_KF_XUPD: state_next = ST_KF_PSET;
            ST_KF_PSET: state_next = ST_KF_PMUL;
            ST_KF_PMUL: state_next = ST_KF_PUPD;
            ST_KF_PUPD: state_next = ST_DONE;
            ST_ZERO:    state_next = ST_DONE;
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = (state_reg == ST_IDLE);
        cmd.sel_cur = (chain_mode == MODE_ALL);
        case (state_reg)
            ST_IDLE:     cmd.op = s_tvalid ? OP_LOAD : OP_NONE;
            ST_LP_SET:   cmd.op = OP_LP_SET;
            ST_LP_UPD:   cmd.op = OP_LP_UPD;
            ST_CF_GSET:  cmd.op = OP_CF_GSET;
            ST_CF_GUPD:  cmd.op = OP_CF_GUPD;
            ST_CF_ASET:  cmd.op = OP_CF_ASET;
            ST_CF_UPD:   cmd.op = OP_CF_UPD;
            ST_KF_P:     cmd.op = OP_KF_P;
            ST_KF_DEN:   cmd.op = OP_KF_DEN;
            ST_KF_DINIT: cmd.op = OP_KF_DINIT;
            ST_KF_DIV:   cmd.op = OP_KF_DIV;
            ST_KF_GAIN:  cmd.op = OP_KF_GAIN;
            ST_KF_XSET:  cmd.op = OP_KF_XSET;
            ST_KF_XUPD:  cmd.op = OP_KF_XUPD;
            ST_KF_PSET:  cmd.op = OP_KF_PSET;
            ST_KF_PUPD:  cmd.op = OP_KF_PUPD;
            ST_LP_MUL, ST_CF_GMUL, ST_CF_AMUL, ST_KF_XMUL, ST_KF_PMUL: cmd.op = OP_MUL;
            ST_ZERO:     cmd.op = OP_ZERO;
            ST_DONE:     cmd.op = OP_EMIT;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/csf_dp.sv -----
// ----------------------------------------------------------------------------
// csf_dp
// Datapath: stage state, shared weight multiplier, serial gain divider and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module csf_dp (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire csf_pkg::cmd_t         cmd,
    output csf_pkg::status_t           status,
    input  wire logic [95:0]           s_tdata,
    input  wire logic [16:0]           lpf_weight,
    input  wire logic [16:0]           cf_weight,
    input  wire logic [30:0]           kf_process_noise,
    input  wire logic [30:0]           kf_measure_noise,
    input  wire logic [16:0]           gyro_dt,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata,
    output logic                       m_tuser
);
    import csf_pkg::*;

    logic signed [DATA_W-1:0] raw_reg, acc_reg, rate_reg, cur_reg;
    logic signed [DATA_W-1:0] smooth_reg, fused_reg, xest_reg, cov_reg;
    logic                     clip_reg;
    logic signed [EXT_W-1:0]  g_reg, opd_reg;
    logic [WEIGHT_W-1:0]      w_reg, gain_reg, q_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic                     neg_reg;
    logic [30:0]              p_reg;
    logic [31:0]              den_reg, rem_reg;
    logic [16:0]              num_reg;
    logic [4:0]               cnt_reg;
    logic                     out_valid_reg, out_sat_reg;
    logic [DATA_W-1:0]        out_data_reg;

    logic [PROD_W-1:0]        rnd;
    logic signed [EXT_W-1:0]  wm;
    logic [EXT_W-1:0]         opd_mag;
    logic signed [EXT_W-1:0]  sum;
    logic [DATA_W:0]          clipped;
    logic [31:0]              psum;
    logic [47:0]              numfull;
    logic [32:0]              remx;
    logic                     ge;
    logic                     out_free;

    // rounded weight product, ties away from zero
    assign rnd     = (prod_reg + PROD_W'(17'h08000)) >> 16;
    assign wm      = neg_reg ? -$signed(rnd[EXT_W-1:0]) : $signed(rnd[EXT_W-1:0]);
    assign opd_mag = opd_reg[EXT_W-1] ? EXT_W'(-opd_reg) : EXT_W'(opd_reg);

    always_comb begin
        case (cmd.op)
            OP_LP_UPD:  sum = EXT_W'(smooth_reg) + wm;
            OP_CF_GUPD: sum = EXT_W'(fused_reg) + wm;
            OP_CF_UPD:  sum = g_reg + wm;
            OP_KF_XUPD: sum = EXT_W'(xest_reg) + wm;
            default:    sum = wm;
        endcase
    end
    assign clipped = clip(sum);

    assign psum    = {1'b0, cov_reg[30:0]} + {1'b0, kf_process_noise};
    assign numfull = {1'b0, p_reg, 16'h0000} + {17'h0_0000, den_reg[31:1]};
    assign remx    = {rem_reg, num_reg[16]};
    assign ge      = (remx >= {1'b0, den_reg});

    assign out_free        = !out_valid_reg || m_tready;
    assign status.out_free = out_free;
    assign status.div_last = (cnt_reg == 5'd0);

    // stage state and flow registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_reg <= '0;
            fused_reg  <= '0;
            xest_reg   <= '0;
            cov_reg    <= '0;
            clip_reg   <= 1'b0;
        end else begin
            case (cmd.op)
                OP_LOAD: clip_reg <= 1'b0;
                OP_LP_UPD: begin
                    smooth_reg <= clipped[DATA_W-1:0];
                    clip_reg   <= clip_reg | clipped[DATA_W];
                end
                OP_CF_UPD: begin
                    fused_reg <= clipped[DATA_W-1:0];
                    clip_reg  <= clip_reg | clipped[DATA_W];
                end
                OP_KF_P: clip_reg <= clip_reg | psum[31];
                OP_KF_XUPD: begin
                    xest_reg <= clipped[DATA_W-1:0];
                    clip_reg <= clip_reg | clipped[DATA_W];
                end
                OP_KF_PUPD: cov_reg <= wm[DATA_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                raw_reg  <= s_tdata[31:0];
                acc_reg  <= s_tdata[63:32];
                rate_reg <= s_tdata[95:64];
                cur_reg  <= s_tdata[31:0];
            end
            OP_LP_SET: begin
                opd_reg <= EXT_W'(raw_reg) - EXT_W'(smooth_reg);
                w_reg   <= wclamp(lpf_weight);
            end
            OP_MUL: begin
                prod_reg <= PROD_W'(opd_mag) * PROD_W'(w_reg);
                neg_reg  <= opd_reg[EXT_W-1];
            end
            OP_LP_UPD:  cur_reg <= clipped[DATA_W-1:0];
            OP_CF_GSET: begin
                opd_reg <= cmd.sel_cur ? EXT_W'(cur_reg) : EXT_W'(rate_reg);
                w_reg   <= wclamp(gyro_dt);
            end
            OP_CF_GUPD: g_reg <= sum;
            OP_CF_ASET: begin
                opd_reg <= EXT_W'(acc_reg) - g_reg;
                w_reg   <= wclamp(cf_weight);
            end
            OP_CF_UPD:  cur_reg <= clipped[DATA_W-1:0];
            OP_KF_P:    p_reg <= psum[31] ? 31'h7FFF_FFFF : psum[30:0];
            OP_KF_DEN:  den_reg <= {1'b0, p_reg} + {1'b0, kf_measure_noise};
            OP_KF_DINIT: begin
                rem_reg <= {1'b0, numfull[47:17]};
                num_reg <= numfull[16:0];
                q_reg   <= '0;
                cnt_reg <= 5'd16;
            end
            OP_KF_DIV: begin
                // one restoring step per cycle, quotient bit from the top
                rem_reg <= ge ? 32'(remx - {1'b0, den_reg}) : remx[31:0];
                q_reg   <= {q_reg[15:0], ge};
                num_reg <= {num_reg[15:0], 1'b0};
                cnt_reg <= cnt_reg - 5'd1;
            end
            OP_KF_GAIN: begin
                if (den_reg == 32'd0) begin
                    gain_reg <= '0;
                end else begin
                    gain_reg <= wclamp(q_reg);
                end
            end
            OP_KF_XSET: begin
                opd_reg <= EXT_W'(cur_reg) - EXT_W'(xest_reg);
                w_reg   <= gain_reg;
            end
            OP_KF_XUPD: cur_reg <= clipped[DATA_W-1:0];
            OP_KF_PSET: begin
                opd_reg <= EXT_W'({1'b0, p_reg});
                w_reg   <= WEIGHT_ONE - gain_reg;
            end
            OP_ZERO:    cur_reg <= '0;
            OP_EMIT: begin
                if (out_free) begin
                    out_data_reg <= cur_reg;
                    out_sat_reg  <= clip_reg;
                end
            end
            default: ;
        endcase
    end

    // result register: hold the word until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.op == OP_EMIT && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

endmodule

`default_nettype wire

// ----- src/cascaded_sensor_filter.sv -----
// ----------------------------------------------------------------------------
// cascaded_sensor_filter
// Low-pass, complementary and scalar Kalman stages in a selectable chain.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one sample per word on s_tdata (raw value,
//   accelerometer angle, gyro rate). Each accepted word produces exactly one
//   result word on m_tdata (filtered value) with m_tuser set when any stage
//   result was clipped to the Q16.16 range.
//   The cfg channel writes the six registers (chain mode, low-pass weight,
//   complementary weight, Kalman Q and R, gyro step); cfg_ready is always
//   high. Write only while no sample is in flight.
//   One sample is processed at a time: the next word is taken in the cycle
//   the sequencer is back in idle, and no word is accepted while a sample
//   is in work. Each stage uses the shared multiplier, one operation per
//   cycle; the Kalman stage adds the 17-step serial gain divider.
//   A finished word waits in the output register while the receiver stalls;
//   the next sample is accepted meanwhile and its result holds until the
//   register frees.
//   Reset (aresetn low, synchronous) clears all stage state to zero and loads
//   the register defaults; no output word is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cascaded_sensor_filter_macros.svh"

module cascaded_sensor_filter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // raw_sample, accel_angle, gyro_rate
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // filtered_value
    output logic             m_tuser,   // saturated
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import csf_pkg::*;

    logic [2:0]  chain_mode_reg;
    logic [16:0] lpf_weight_reg, cf_weight_reg, gyro_dt_reg;
    logic [30:0] kf_q_reg, kf_r_reg;
    cmd_t        cmd;
    status_t     status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_mode_reg <= MODE_ALL;
            lpf_weight_reg <= 17'd65536;
            cf_weight_reg  <= 17'd64225;
            kf_q_reg       <= 31'd66;
            kf_r_reg       <= 31'd6554;
            gyro_dt_reg    <= 17'd328;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CHAIN_MODE: chain_mode_reg <= cfg_data[2:0];
                REG_LPF_WEIGHT: lpf_weight_reg <= cfg_data[16:0];
                REG_CF_WEIGHT:  cf_weight_reg  <= cfg_data[16:0];
                REG_KF_Q:       kf_q_reg       <= cfg_data[30:0];
                REG_KF_R:       kf_r_reg       <= cfg_data[30:0];
                REG_GYRO_DT:    gyro_dt_reg    <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    csf_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .chain_mode (chain_mode_reg),
        .status     (status),
        .cmd        (cmd)
    );

    csf_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_tdata          (s_tdata),
        .lpf_weight       (lpf_weight_reg),
        .cf_weight        (cf_weight_reg),
        .kf_process_noise (kf_q_reg),
        .kf_measure_noise (kf_r_reg),
        .gyro_dt          (gyro_dt_reg),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser)
    );

    // a sample in work blocks the next one
    `CSF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // a result word only appears after the sequencer has left idle
    `CSF_ASSERT_IMPL(a_result_from_work, $rose(m_tvalid), $past(!s_tready))

endmodule

`default_nettype wire
